// ----- design/sparse_sign_index_sampler_core_assert.svh -----
// assertion macros for the sparse sign index sampler
// no dependencies; taken in by the modules that carry assertions
`ifndef SPARSE_SIGN_INDEX_SAMPLER_CORE_ASSERT_SVH
`define SPARSE_SIGN_INDEX_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SSIS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SSIS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ssis_pkg.sv -----
// shared widths, register codes and types of the sparse sign index sampler
// no dependencies; used by scoped names from ssis_mod_unit and the core
package ssis_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned VCNT_W      = 17;
  localparam int unsigned VNUM_W      = 16;
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - INDEX_W - VNUM_W - 1;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 17;

  // remainder unit: quotient bits resolved per cycle
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_CYCLES = WORD_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [CFG_ADDR_W-1:0] REG_VECTOR_LENGTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NONZEROS       = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VECTOR_COUNT   = 2'd2;

  localparam logic [LEN_W-1:0]  RST_VECTOR_LENGTH = 11'd1024;
  localparam logic [LEN_W-1:0]  RST_NONZEROS      = 11'd8;
  localparam logic [VCNT_W-1:0] RST_VECTOR_COUNT  = 17'd65536;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [LEN_W-1:0]  divisor;
  } div_req_t;

endpackage

// ----- design/ssis_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ssis_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  logic [WIDTH-1:0]                 wr_data_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic [WIDTH-1:0]                 rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/ssis_mod_unit.sv -----
// iterative remainder unit: 64-bit word modulo an 11-bit divisor
// depends on ssis_pkg and the assertion macro header
`include "sparse_sign_index_sampler_core_assert.svh"

module ssis_mod_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ssis_pkg::div_req_t       req_i,
  output logic                     done_o,
  output logic [ssis_pkg::LEN_W-1:0] rem_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [ssis_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [ssis_pkg::WORD_W-1:0]       dvd_q;
  logic [ssis_pkg::LEN_W-1:0]        den_q;
  logic [ssis_pkg::LEN_W-1:0]        rem_q;
  logic [ssis_pkg::LEN_W-1:0]        rem_step;

  // restoring remainder, a few dividend bits per cycle
  always_comb begin : p_step
    logic [ssis_pkg::LEN_W:0]   t;
    logic [ssis_pkg::LEN_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < ssis_pkg::DIV_STEPS; i++) begin
      t = {r, dvd_q[ssis_pkg::WORD_W-1-i]};
      if (t >= {1'b0, den_q}) begin
        r = ssis_pkg::LEN_W'(t - {1'b0, den_q});
      end else begin
        r = t[ssis_pkg::LEN_W-1:0];
      end
    end
    rem_step = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ssis_pkg::DIV_CNT_W'(ssis_pkg::DIV_CYCLES - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << ssis_pkg::DIV_STEPS;
      rem_q <= rem_step;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  `SSIS_ASSERT_IMPL(a_rem_below_divisor, clk_i, rst_ni, done_q, rem_q < den_q, "remainder not below divisor")
  `SSIS_ASSERT_IMPL(a_no_start_while_busy, clk_i, rst_ni, req_i.start, !busy_q, "start while busy")
  `SSIS_ASSERT_IMPL(a_done_after_busy, clk_i, rst_ni, done_q, $past(busy_q), "done without a run")

endmodule

// ----- design/sparse_sign_index_sampler_core.sv -----
// Sparse sign index sampler. Each input word carries a 64-bit random word and a sign bit;
// each produces one output word with the sampled index, the vector number, the sign and a
// last flag on the final nonzero of a vector. Indices are drawn without repetition by a
// partial Fisher-Yates shuffle over a permutation ram: pivot = step + (word mod (L - step)).
// Each item runs through the iterative remainder unit (4 dividend bits a cycle), then the
// ram read, two swap writes and the result handoff, all through a single-port-per-direction
// permutation ram. After the last nonzero of a vector the swaps are undone newest first,
// each through the undo states A to D, before the next item is taken; a register write in
// mid-vector runs the same undo pass and restarts the vector. After reset a clearing pass
// loads the identity permutation into every entry; input words wait during it, register
// writes are taken. The output register lets a result wait for the sink while the next item
// is already being worked on; a new input word is taken only once the result is handed off.
// depends on ssis_pkg, ssis_ram, ssis_mod_unit and the assertion macro header
`include "sparse_sign_index_sampler_core_assert.svh"

module sparse_sign_index_sampler_core #(
  parameter int unsigned     MAX_VECTOR_LENGTH = 1024,
  parameter longint unsigned MAX_VECTORS       = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [63:0] random_pivot_word, [64] random_sign_bit, [71:65] zero
  input  logic [ssis_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [9:0] chosen_index, [25:10] vector_number, [26] negative, [31:27] zero
  output logic [ssis_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast,   // last_of_vector
  // register write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ssis_pkg::CFG_ADDR_W-1:0]     cfg_index_i,
  input  logic [ssis_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W  = $clog2(MAX_VECTOR_LENGTH);
  localparam int unsigned HIST_W = 2 * IDX_W;
  localparam int unsigned LEN_W  = ssis_pkg::LEN_W;
  localparam int unsigned VCNT_W = ssis_pkg::VCNT_W;

  // sequencer states
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DIV    = 4'd2;
  localparam logic [3:0] ST_SWAP1  = 4'd3;
  localparam logic [3:0] ST_SWAP2  = 4'd4;
  localparam logic [3:0] ST_EMIT   = 4'd5;
  localparam logic [3:0] ST_UNDO_A = 4'd6;
  localparam logic [3:0] ST_UNDO_B = 4'd7;
  localparam logic [3:0] ST_UNDO_C = 4'd8;
  localparam logic [3:0] ST_UNDO_D = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [LEN_W-1:0]  step_q, step_d;     // nonzeros drawn in the current vector
  logic [LEN_W-1:0]  undo_q, undo_d;     // swaps still to undo
  logic [VCNT_W-1:0] vnum_q, vnum_d;
  logic [IDX_W-1:0]  clr_q, clr_d;

  // configuration registers
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  nz_q, nz_d;
  logic [VCNT_W-1:0] cnt_q, cnt_d;

  // item payload
  logic              sign_q;
  logic [IDX_W-1:0]  pivot_q;
  logic [IDX_W-1:0]  permj_q;
  logic [IDX_W-1:0]  chosen_q;

  // output register
  logic                         out_valid_q;
  logic [ssis_pkg::INDEX_W-1:0] out_idx_q;
  logic [ssis_pkg::VNUM_W-1:0]  out_vnum_q;
  logic                         out_neg_q;
  logic                         out_last_q;
  logic                         out_load;

  // effective (clamped) settings
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  nz_raw;
  logic [LEN_W-1:0]  eff_n;
  logic [VCNT_W-1:0] cnt_raw;
  logic [VCNT_W-1:0] eff_cnt;
  logic [VCNT_W-1:0] vnum_next;
  logic              last_c;
  logic              in_accept;
  logic              cfg_hit;

  // ram ports
  logic              perm_we, perm_re;
  logic [IDX_W-1:0]  perm_waddr, perm_raddr, perm_wdata, perm_rdata;
  logic              hist_we, hist_re;
  logic [IDX_W-1:0]  hist_raddr;
  logic [HIST_W-1:0] hist_rdata;
  logic [IDX_W-1:0]  hist_piv, hist_ch;

  // remainder unit
  ssis_pkg::div_req_t div_req;
  logic               div_done;
  logic [LEN_W-1:0]   div_rem;
  logic [IDX_W-1:0]   pivot_c;

  assign eff_len = (len_q == '0) ? LEN_W'(1)
                 : ((32'(len_q) > MAX_VECTOR_LENGTH) ? LEN_W'(MAX_VECTOR_LENGTH) : len_q);
  assign nz_raw  = (nz_q == '0) ? LEN_W'(1) : nz_q;
  assign eff_n   = (nz_raw > eff_len) ? eff_len : nz_raw;
  assign cnt_raw = (cnt_q == '0) ? VCNT_W'(1) : cnt_q;
  assign eff_cnt = (64'(cnt_raw) > MAX_VECTORS) ? VCNT_W'(MAX_VECTORS) : cnt_raw;
  assign vnum_next = (({1'b0, vnum_q} + (VCNT_W+1)'(1)) >= {1'b0, eff_cnt})
                   ? '0 : (vnum_q + VCNT_W'(1));
  assign last_c  = (step_q + LEN_W'(1)) >= eff_n;

  // handshakes: input only in idle, register writes also during the clearing pass
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == ST_IDLE) || (state_q == ST_CLEAR);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_hit       = cfg_valid_i && cfg_ready_o && (cfg_index_i <= ssis_pkg::REG_VECTOR_COUNT);

  assign div_req.start    = in_accept;
  assign div_req.dividend = s_axis_tdata[ssis_pkg::WORD_W-1:0];
  assign div_req.divisor  = eff_len - step_q;
  assign pivot_c          = IDX_W'(step_q + div_rem);

  assign hist_piv = hist_rdata[HIST_W-1:IDX_W];
  assign hist_ch  = hist_rdata[IDX_W-1:0];

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    undo_d     = undo_q;
    vnum_d     = vnum_q;
    clr_d      = clr_q;
    len_d      = len_q;
    nz_d       = nz_q;
    cnt_d      = cnt_q;
    perm_we    = 1'b0;
    perm_waddr = clr_q;
    perm_wdata = clr_q;
    perm_re    = 1'b0;
    perm_raddr = IDX_W'(step_q);
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    hist_raddr = IDX_W'(undo_q - LEN_W'(1));
    out_load   = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // identity fill, one entry a cycle
        perm_we = 1'b1;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IDX_W'(MAX_VECTOR_LENGTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          // fetch the entry at the current step while the remainder runs
          perm_re = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          perm_re    = 1'b1;
          perm_raddr = pivot_c;
          state_d    = ST_SWAP1;
        end
      end
      ST_SWAP1: begin
        // read data is the chosen value; move the step entry to the pivot
        perm_we    = 1'b1;
        perm_waddr = pivot_q;
        perm_wdata = permj_q;
        hist_we    = 1'b1;
        state_d    = ST_SWAP2;
      end
      ST_SWAP2: begin
        perm_we    = 1'b1;
        perm_waddr = IDX_W'(step_q);
        perm_wdata = chosen_q;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          if (last_c) begin
            undo_d  = step_q + LEN_W'(1);
            step_d  = '0;
            vnum_d  = vnum_next;
            state_d = ST_UNDO_A;
          end else begin
            step_d  = step_q + LEN_W'(1);
            state_d = ST_IDLE;
          end
        end
      end
      ST_UNDO_A: begin
        // newest swap first
        if (undo_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          hist_re = 1'b1;
          undo_d  = undo_q - LEN_W'(1);
          state_d = ST_UNDO_B;
        end
      end
      ST_UNDO_B: begin
        perm_re    = 1'b1;
        perm_raddr = hist_piv;
        state_d    = ST_UNDO_C;
      end
      ST_UNDO_C: begin
        perm_we    = 1'b1;
        perm_waddr = IDX_W'(undo_q);
        perm_wdata = perm_rdata;
        state_d    = ST_UNDO_D;
      end
      ST_UNDO_D: begin
        perm_we    = 1'b1;
        perm_waddr = hist_piv;
        perm_wdata = hist_ch;
        state_d    = ST_UNDO_A;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register write: restart the vector, undoing what it has swapped so far
    if (cfg_hit) begin
      case (cfg_index_i)
        ssis_pkg::REG_VECTOR_LENGTH: len_d = cfg_data_i[LEN_W-1:0];
        ssis_pkg::REG_NONZEROS:      nz_d  = cfg_data_i[LEN_W-1:0];
        ssis_pkg::REG_VECTOR_COUNT:  cnt_d = cfg_data_i[VCNT_W-1:0];
        default:                     len_d = len_q;
      endcase
      if ((state_q == ST_IDLE) && (step_q != '0)) begin
        undo_d  = step_q;
        step_d  = '0;
        state_d = ST_UNDO_A;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      undo_q      <= '0;
      vnum_q      <= '0;
      clr_q       <= '0;
      len_q       <= ssis_pkg::RST_VECTOR_LENGTH;
      nz_q        <= ssis_pkg::RST_NONZEROS;
      cnt_q       <= ssis_pkg::RST_VECTOR_COUNT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      undo_q  <= undo_d;
      vnum_q  <= vnum_d;
      clr_q   <= clr_d;
      len_q   <= len_d;
      nz_q    <= nz_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sign_q <= s_axis_tdata[ssis_pkg::WORD_W];
    end
    if ((state_q == ST_DIV) && div_done) begin
      pivot_q <= pivot_c;
      permj_q <= perm_rdata;
    end
    if (state_q == ST_SWAP1) begin
      chosen_q <= perm_rdata;
    end
    if (out_load) begin
      out_idx_q  <= ssis_pkg::INDEX_W'(chosen_q);
      out_vnum_q <= ssis_pkg::VNUM_W'(vnum_q);
      out_neg_q  <= sign_q;
      out_last_q <= last_c;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{ssis_pkg::OUT_PAD_W{1'b0}}, out_neg_q, out_vnum_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

  ssis_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  // permutation store
  ssis_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_VECTOR_LENGTH)
  ) u_perm_ram (
    .clk_i     (clk_i),
    .wr_en_i   (perm_we),
    .wr_addr_i (perm_waddr),
    .wr_data_i (perm_wdata),
    .rd_en_i   (perm_re),
    .rd_addr_i (perm_raddr),
    .rd_data_o (perm_rdata)
  );

  // per-step history: pivot and chosen value
  ssis_ram #(
    .WIDTH (HIST_W),
    .DEPTH (MAX_VECTOR_LENGTH)
  ) u_hist_ram (
    .clk_i     (clk_i),
    .wr_en_i   (hist_we),
    .wr_addr_i (IDX_W'(step_q)),
    .wr_data_i ({pivot_q, perm_rdata}),
    .rd_en_i   (hist_re),
    .rd_addr_i (hist_raddr),
    .rd_data_o (hist_rdata)
  );

  `SSIS_ASSERT_IMPL(a_step_in_range, clk_i, rst_ni, state_q == ST_IDLE, step_q < eff_n, "step count beyond nonzeros per vector")
  `SSIS_ASSERT_IMPL(a_pivot_in_window, clk_i, rst_ni, state_q == ST_SWAP1, (32'(pivot_q) < 32'(eff_len)) && (32'(pivot_q) >= 32'(step_q)), "pivot outside remaining window")
  `SSIS_ASSERT_IMPL(a_vnum_moves_on_last, clk_i, rst_ni, vnum_d != vnum_q, (state_q == ST_EMIT) && out_load && last_c, "vector number moved without a last nonzero")
  `SSIS_ASSERT_IMPL(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == ST_DIV, "remainder finished outside its wait state")

endmodule

// ----- tb/sparse_sign_index_sampler_core_tb.sv -----
// self-checking testbench for sparse_sign_index_sampler_core: directed table, then random phases
// depends on ssis_pkg and the sparse_sign_index_sampler_core rtl
module sparse_sign_index_sampler_core_tb;
  import ssis_pkg::*;

  localparam int unsigned MAX_LEN      = 1024;
  localparam int unsigned MAX_VEC      = 65536;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned HOLD_CYCLES  = 400;    // long sink stall so the block backs up
  localparam int unsigned QUIET_LIMIT  = 20000;  // cycles without any handshake
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_OF_RANGE = 2'd3;

  // one output word, split into its fields
  typedef struct packed {
    logic [INDEX_W-1:0] chosen_index;
    logic [VNUM_W-1:0]  vector_number;
    logic               negative;
    logic               last_of_vector;
  } sample_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_REG_WRITE} row_kind_e;

  // one step of the directed part; typed rows carry their result, the rest use the predictor
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_ADDR_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [WORD_W-1:0]     word;
    logic                  sign;
    logic                  typed;
    sample_result_t        result;
  } plan_row_t;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  localparam plan_row_t DIRECTED_PLAN [27] = '{
    // after reset: L 1024, N 8, first pivot of a zero word is entry 0
    '{ROW_SAMPLE, '0, '0, 64'd0, 1'b0, 1'b1, '{10'd0, 16'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, '0, ALL_ONES, 1'b1, 1'b0, '0},
    // unknown register index leaves the vector alone
    '{ROW_REG_WRITE, REG_OUT_OF_RANGE, 17'h1FFFF, '0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 64'h8000_0000_0000_0001, 1'b0, 1'b0, '0},
    // length zero clamps to one, mid-vector write restarts vector 0
    '{ROW_REG_WRITE, REG_VECTOR_LENGTH, 17'd0, '0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, ALL_ONES, 1'b1, 1'b1, '{10'd0, 16'd0, 1'b1, 1'b1}},
    '{ROW_SAMPLE, '0, '0, 64'd0, 1'b0, 1'b1, '{10'd0, 16'd1, 1'b0, 1'b1}},
    // count zero clamps to one: vector number drops back to zero
    '{ROW_REG_WRITE, REG_VECTOR_COUNT, 17'd0, '0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 64'd5, 1'b1, 1'b1, '{10'd0, 16'd2, 1'b1, 1'b1}},
    '{ROW_SAMPLE, '0, '0, 64'd6, 1'b0, 1'b1, '{10'd0, 16'd0, 1'b0, 1'b1}},
    // all registers out of range: count and length too large, nonzeros zero
    '{ROW_REG_WRITE, REG_VECTOR_COUNT, 17'h1FFFF, '0, 1'b0, 1'b0, '0},
    '{ROW_REG_WRITE, REG_NONZEROS, 17'd0, '0, 1'b0, 1'b0, '0},
    '{ROW_REG_WRITE, REG_VECTOR_LENGTH, 17'h007FF, '0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 64'h3FF, 1'b0, 1'b1, '{10'd1023, 16'd0, 1'b0, 1'b1}},
    '{ROW_SAMPLE, '0, '0, 64'hFFFF_FFFF_FFFF_FC00, 1'b1, 1'b1, '{10'd0, 16'd1, 1'b1, 1'b1}},
    // more nonzeros than entries: N follows L, whole permutation drawn
    '{ROW_REG_WRITE, REG_VECTOR_LENGTH, 17'd5, '0, 1'b0, 1'b0, '0},
    '{ROW_REG_WRITE, REG_NONZEROS, 17'h007FF, '0, 1'b0, 1'b0, '0},
    '{ROW_REG_WRITE, REG_VECTOR_COUNT, 17'd3, '0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, ALL_ONES, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 64'd7, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 64'h5555_AAAA_5555_AAAA, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 64'd0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 64'h0F0F_F0F0_1234_8765, 1'b1, 1'b0, '0},
    // upper data bits are dropped for the length register
    '{ROW_REG_WRITE, REG_VECTOR_LENGTH, 17'h1F802, '0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 64'h7777_0000_FFFF_0001, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, ALL_ONES, 1'b1, 1'b0, '0}
  };

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_ADDR_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;

  sparse_sign_index_sampler_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shuffle predictor: permutation, per-step swap log, step and vector counters
  // ---------------------------------------------------------------------------
  logic [INDEX_W-1:0] perm_model  [MAX_LEN];
  logic [INDEX_W-1:0] step_pivot  [MAX_LEN];
  logic [INDEX_W-1:0] step_chosen [MAX_LEN];
  int unsigned        step_index;
  int unsigned        vector_no;
  logic [LEN_W-1:0]   reg_length;
  logic [LEN_W-1:0]   reg_nonzeros;
  logic [VCNT_W-1:0]  reg_count;

  sample_result_t pending_samples [$];  // results still owed by the block
  int unsigned    mismatch_count = 0;
  bit             settle_needed  = 1'b0;
  bit             sender_burst   = 1'b0;
  bit             hold_request   = 1'b0;

  function automatic int unsigned clamped_length();
    if (reg_length == 0) return 1;
    if (reg_length > MAX_LEN) return MAX_LEN;
    return reg_length;
  endfunction

  function automatic int unsigned clamped_nonzeros();
    int unsigned len;
    len = clamped_length();
    if (reg_nonzeros == 0) return 1;
    if (reg_nonzeros > len) return len;
    return reg_nonzeros;
  endfunction

  function automatic int unsigned clamped_count();
    if (reg_count == 0) return 1;
    if (reg_count > MAX_VEC) return MAX_VEC;
    return reg_count;
  endfunction

  // put the swaps of the current vector back, newest first
  function automatic void unwind_swaps(int unsigned steps);
    for (int k = int'(steps) - 1; k >= 0; k--) begin
      perm_model[k]             = perm_model[step_pivot[k]];
      perm_model[step_pivot[k]] = step_chosen[k];
    end
  endfunction

  function automatic void reset_predictor();
    for (int k = 0; k < MAX_LEN; k++) begin
      perm_model[k]  = INDEX_W'(k);
      step_pivot[k]  = '0;
      step_chosen[k] = '0;
    end
    step_index   = 0;
    vector_no    = 0;
    reg_length   = RST_VECTOR_LENGTH;
    reg_nonzeros = RST_NONZEROS;
    reg_count    = RST_VECTOR_COUNT;
  endfunction

  // any valid register write restarts the vector with the same number
  function automatic void record_reg_write(logic [CFG_ADDR_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
    if (idx == REG_OUT_OF_RANGE) return;
    unwind_swaps(step_index);
    step_index = 0;
    case (idx)
      REG_VECTOR_LENGTH: reg_length   = data[LEN_W-1:0];
      REG_NONZEROS:      reg_nonzeros = data[LEN_W-1:0];
      default:           reg_count    = data;
    endcase
  endfunction

  // one shuffle step: pivot = step + word mod (L - step), swap, log it
  function automatic sample_result_t draw_sample(logic [WORD_W-1:0] word, logic sign);
    int unsigned       len;
    int unsigned       nz;
    int unsigned       j;
    int unsigned       pivot;
    logic [WORD_W-1:0] span;
    sample_result_t    res;
    len = clamped_length();
    nz  = clamped_nonzeros();
    j   = step_index;
    if (j >= nz) begin
      unwind_swaps(j);
      j = 0;
    end
    span  = WORD_W'(len - j);
    pivot = j + 32'(word % span);
    res.chosen_index   = perm_model[pivot];
    perm_model[pivot]  = perm_model[j];
    perm_model[j]      = res.chosen_index;
    step_pivot[j]      = pivot[INDEX_W-1:0];
    step_chosen[j]     = res.chosen_index;
    res.vector_number  = vector_no[VNUM_W-1:0];
    res.negative       = sign;
    res.last_of_vector = 1'b0;
    j++;
    if (j >= nz) begin
      res.last_of_vector = 1'b1;
      unwind_swaps(j);
      j = 0;
      vector_no = (vector_no + 1 >= clamped_count()) ? 0 : vector_no + 1;
    end
    step_index = j;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers: everything changes on the falling edge, handshakes seen on the rising one
  // ---------------------------------------------------------------------------
  task automatic offer_sample(input logic [WORD_W-1:0] word, input logic sign,
                              input logic typed, input sample_result_t typed_result);
    int unsigned    gap;
    sample_result_t predicted;
    if ($urandom_range(0, 79) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - WORD_W - 1){1'b0}}, sign, word};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = draw_sample(word, sign);
    pending_samples.push_back(typed ? typed_result : predicted);
    settle_needed = 1'b1;
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    record_reg_write(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering, let every owed result arrive, then cover a full undo pass
  task automatic drain_and_settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    if (settle_needed) repeat (4 * clamped_nonzeros() + 64) @(posedge clk_i);
    settle_needed = 1'b0;
  endtask

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result sink: random back-pressure, one long stall on request, field checks
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned    gap;
    bit             burst;
    sample_result_t got;
    sample_result_t want;
    burst = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if ($urandom_range(0, 59) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 6);
      @(negedge clk_i);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.chosen_index   = m_axis_tdata[INDEX_W-1:0];
      got.vector_number  = m_axis_tdata[INDEX_W+VNUM_W-1:INDEX_W];
      got.negative       = m_axis_tdata[INDEX_W+VNUM_W];
      got.last_of_vector = m_axis_tlast;
      if (pending_samples.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, expected none, actual index %0d vector %0d",
                 $time, got.chosen_index, got.vector_number);
      end else begin
        want = pending_samples.pop_front();
        compare_field("chosen_index", want.chosen_index, got.chosen_index);
        compare_field("vector_number", want.vector_number, got.vector_number);
        compare_field("negative", want.negative, got.negative);
        compare_field("last_of_vector", want.last_of_vector, got.last_of_vector);
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed table, then random phases of settings and items
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned       random_sent;
    int unsigned       phase_no;
    int unsigned       phase_items;
    int unsigned       nz;
    int unsigned       pick;
    int unsigned       value;
    bit                wrote;
    logic [WORD_W-1:0] word;
    random_sent = 0;
    phase_no    = 0;
    reset_predictor();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_PLAN[r]) begin
      if (DIRECTED_PLAN[r].kind == ROW_REG_WRITE) begin
        drain_and_settle();
        write_register(DIRECTED_PLAN[r].reg_index, DIRECTED_PLAN[r].reg_data);
      end else begin
        offer_sample(DIRECTED_PLAN[r].word, DIRECTED_PLAN[r].sign,
                     DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].result);
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      // new settings only once the block has gone quiet; items may end mid-vector
      drain_and_settle();
      wrote = 1'b0;
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0:       value = 0;
          1:       value = $urandom_range(1025, 2047);
          2:       value = MAX_LEN;
          3, 4:    value = $urandom_range(33, MAX_LEN);
          default: value = $urandom_range(1, 32);
        endcase
        write_register(REG_VECTOR_LENGTH, {6'($urandom), 11'(value)});
        wrote = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0:       value = 0;
          1:       value = 2047;
          2, 3:    value = $urandom_range(17, MAX_LEN);
          default: value = $urandom_range(1, 16);
        endcase
        write_register(REG_NONZEROS, {6'($urandom), 11'(value)});
        wrote = 1'b1;
      end
      if ($urandom_range(0, 2) != 0 || !wrote) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0:       value = 0;
          1:       value = 17'h1FFFF;
          2:       value = MAX_VEC;
          3:       value = 17'($urandom);
          default: value = $urandom_range(1, 6);
        endcase
        write_register(REG_VECTOR_COUNT, 17'(value));
      end
      if ($urandom_range(0, 4) == 0) write_register(REG_OUT_OF_RANGE, 17'($urandom));

      // a few whole vectors plus a partial one, capped to keep long vectors cheap
      nz = clamped_nonzeros();
      phase_items = nz * $urandom_range(1, 3) + $urandom_range(0, nz - 1);
      if (phase_items > 250) phase_items = $urandom_range(40, 250);
      if (phase_no == 3) begin
        // sink stalls for a long stretch while items keep coming
        phase_items  = 120;
        hold_request = 1'b1;
      end
      repeat (phase_items) begin
        pick = $urandom_range(0, 15);
        case (pick)
          0:       word = '0;
          1:       word = ALL_ONES;
          2:       word = WORD_W'($urandom_range(0, 2047));
          default: word = {$urandom, $urandom};
        endcase
        offer_sample(word, 1'($urandom), 1'b0, '0);
        random_sent++;
      end
      phase_no++;
    end

    settle_needed = 1'b1;
    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sparse_sign_index_sampler_core.f -----
+incdir+design
design/ssis_pkg.sv
design/ssis_ram.sv
design/ssis_mod_unit.sv
design/sparse_sign_index_sampler_core.sv
tb/sparse_sign_index_sampler_core_tb.sv
